// ===== rtl/task_completion_watermark_defines.svh =====
// ----------------------------------------------------------------------------
// Task completion watermark: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TASK_COMPLETION_WATERMARK_DEFINES_SVH
`define TASK_COMPLETION_WATERMARK_DEFINES_SVH

`ifndef SYNTHESIS
// check under reset gating
`define TCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(label, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Task completion watermark: shared package
// Widths, codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // field widths
   localparam int ID_W        = 32;
   localparam int BYTES_W     = 63;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 63;

   // stream packing
   localparam int REQ_TDATA_W  = 96;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 192;
   localparam int RSP_TUSER_W  = 4;
   localparam int RSP_FIELDS_W = 2 * ID_W + 2 * BYTES_W;

   // outstanding window
   localparam int WINDOW_DEFAULT = 64;
   localparam int CHUNK          = 16;  // map slots examined per scan cycle
   localparam int CHUNK_W        = 4;

   localparam logic [ID_W-1:0] REPORT_INTERVAL_RESET = 32'd128;

   // request operations
   localparam logic [OP_W-1:0] OP_ISSUE    = 2'd0;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART  = 2'd2;

   // response status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STRAY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_TASKS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUME_TASK_ID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUME_BYTES    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_INTERVAL = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic exec;      // apply the operation
      logic scan;      // examine one chunk of the map
      logic chkpt;     // form the new checkpoint
      logic decide;    // evaluate the report condition
      logic out_load;  // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;  // lowest outstanding id was completed
      logic scan_end;   // scan hit or ran out of chunks
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Task completion watermark: controller
// Sequences one request at a time through execute, map scan, checkpoint and
// report phases, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_completion_watermark_defines.svh"

module tcw_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output tcw_pkg::cmd_type   cmd,
   input  tcw_pkg::stat_type  stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_CHKPT,
      ST_DECIDE,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_scan ? ST_SCAN : ST_OUTPUT;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_end) state_in = ST_CHKPT;
         end
         ST_CHKPT: begin
            cmd.chkpt = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // reset leaves the sequencer idle with no pending response
   `TCW_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "controller not idle after reset")
   // a new result never overwrites one that was not taken
   `TCW_ASSERT(a_no_overwrite, clock, reset, cmd.out_load |-> (!rsp_valid_ff || rsp_tready), "response overwritten")

endmodule

`default_nettype wire

// ===== rtl/tcw_dpath.sv =====
// ----------------------------------------------------------------------------
// Task completion watermark: datapath
// Configuration registers, outstanding map, id and byte counters, chunked
// lowest-id scan, report decision and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_completion_watermark_defines.svh"

module tcw_dpath #(
   parameter int WINDOW = tcw_pkg::WINDOW_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  tcw_pkg::cmd_type                      cmd,
   output tcw_pkg::stat_type                     stat,
   input  wire  [tcw_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  wire  [tcw_pkg::REQ_TUSER_W-1:0]       req_tuser,
   input  wire                                   csr_we,
   input  wire  [tcw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [tcw_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic [tcw_pkg::RSP_TUSER_W-1:0]       rsp_tuser
);

   localparam int ID_W       = tcw_pkg::ID_W;
   localparam int BYTES_W    = tcw_pkg::BYTES_W;
   localparam int CHUNK      = tcw_pkg::CHUNK;
   localparam int CHUNK_W    = tcw_pkg::CHUNK_W;
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int SLOT_SPAN  = 1 << SLOT_W;
   localparam int NCHUNK     = (SLOT_SPAN + CHUNK - 1) / CHUNK;
   localparam int CIDX_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_SLOT_W = CIDX_W + CHUNK_W;
   localparam int PAD_W      = 1 << PAD_SLOT_W;
   localparam int VCNT_W     = $clog2(NCHUNK + 1);
   localparam int OFF_W      = PAD_SLOT_W + 1;

   // saturating 63-bit add
   function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                  input logic [BYTES_W-1:0] b);
      logic [BYTES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
   endfunction

   // index of the lowest set bit
   function automatic logic [CHUNK_W-1:0] lowest_set(input logic [CHUNK-1:0] v);
      logic [CHUNK_W-1:0] r;
      r = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (v[i]) r = CHUNK_W'(i);
      end
      return r;
   endfunction

   // configuration
   logic [ID_W-1:0]    total_ff, total_in;
   logic [ID_W-1:0]    resume_id_ff, resume_id_in;
   logic [BYTES_W-1:0] resume_bytes_ff, resume_bytes_in;
   logic [ID_W-1:0]    interval_ff, interval_in;

   // captured request
   logic [tcw_pkg::OP_W-1:0] op_ff, op_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic [BYTES_W-1:0]       bytes_ff, bytes_in;

   // tracking state
   logic [WINDOW-1:0]  map_ff, map_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [ID_W-1:0]    base_ff, base_in;
   logic [SLOT_W-1:0]  base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0]  next_slot_ff, next_slot_in;
   logic [ID_W-1:0]    last_ff, last_in;
   logic [BYTES_W-1:0] btotal_ff, btotal_in;
   logic [BYTES_W-1:0] bsince_ff, bsince_in;

   // scan state
   logic [CIDX_W-1:0]     cur_chunk_ff, cur_chunk_in;
   logic [VCNT_W-1:0]     vcnt_ff, vcnt_in;
   logic                  found_ff, found_in;
   logic [PAD_SLOT_W-1:0] found_slot_ff, found_slot_in;
   logic [ID_W-1:0]       cp_ff, cp_in;

   // staged result
   logic                           res_issued_ff, res_issued_in;
   logic [ID_W-1:0]                res_issued_id_ff, res_issued_id_in;
   logic                           res_report_ff, res_report_in;
   logic [ID_W-1:0]                res_cp_ff, res_cp_in;
   logic [BYTES_W-1:0]             res_delta_ff, res_delta_in;
   logic [BYTES_W-1:0]             res_total_ff, res_total_in;
   logic [tcw_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;

   // output register
   logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [tcw_pkg::RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   // helpers
   logic [PAD_W-1:0]      map_pad;
   logic [ID_W-1:0]       span;
   logic [ID_W-1:0]       off_c;
   logic                  in_win;
   logic [SLOT_W:0]       slot_sum;
   logic [SLOT_W-1:0]     slot_c;
   logic                  valid_c;
   logic [PAD_SLOT_W-1:0] s_pad;
   logic [CIDX_W-1:0]     s_chunk;
   logic [CHUNK_W-1:0]    s_lo;
   logic [CHUNK-1:0]      chunk_bits;
   logic [CHUNK-1:0]      keep;
   logic [CHUNK-1:0]      masked;
   logic                  hit;
   logic [CHUNK_W-1:0]    lo_idx;
   logic                  last_visit;
   logic [CIDX_W-1:0]     chunk_nxt;
   logic [SLOT_W-1:0]     next_slot_inc;
   logic [OFF_W-1:0]      off_f;
   logic [ID_W-1:0]       cp_found;
   logic [ID_W-1:0]       cp_none;
   logic                  report;

   assign map_pad = PAD_W'(map_ff);
   assign span    = next_id_ff - base_ff;

   // slot of the completed id, relative to the window base
   assign off_c    = id_ff - base_ff;
   assign in_win   = (id_ff >= base_ff) && (id_ff < next_id_ff);
   assign slot_sum = {1'b0, base_slot_ff} + {1'b0, off_c[SLOT_W-1:0]};
   assign slot_c   = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
                     SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];
   assign valid_c  = in_win && map_pad[PAD_SLOT_W'(slot_c)];

   assign next_slot_inc = (next_slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : next_slot_ff + 1'b1;

   // chunk scan: start chunk above the base slot, middle chunks, start chunk below
   assign s_pad      = PAD_SLOT_W'(base_slot_ff);
   assign s_chunk    = s_pad[PAD_SLOT_W-1:CHUNK_W];
   assign s_lo       = s_pad[CHUNK_W-1:0];
   assign chunk_bits = map_pad[{cur_chunk_ff, {CHUNK_W{1'b0}}} +: CHUNK];
   assign last_visit = (vcnt_ff == VCNT_W'(NCHUNK));

   always_comb begin
      for (int i = 0; i < CHUNK; i++) begin
         if (vcnt_ff == '0)   keep[i] = (CHUNK_W'(i) >= s_lo);
         else if (last_visit) keep[i] = (CHUNK_W'(i) < s_lo);
         else                 keep[i] = 1'b1;
      end
   end

   assign masked    = chunk_bits & keep;
   assign hit       = |masked;
   assign lo_idx    = lowest_set(masked);
   assign chunk_nxt = (cur_chunk_ff == CIDX_W'(NCHUNK - 1)) ? '0 : cur_chunk_ff + 1'b1;

   // checkpoint candidates
   assign off_f    = (found_slot_ff >= s_pad) ?
                     OFF_W'(found_slot_ff) - OFF_W'(s_pad) :
                     OFF_W'(found_slot_ff) + OFF_W'(WINDOW) - OFF_W'(s_pad);
   assign cp_found = base_ff + ID_W'(off_f);
   assign cp_none  = (next_id_ff >= total_ff) ? total_ff : next_id_ff;

   // report when the job is done or the checkpoint moved far enough
   assign report = (cp_ff == total_ff) ||
                   ((cp_ff >= last_ff) && ((cp_ff - last_ff) >= interval_ff));

   assign stat.need_scan = (op_ff == tcw_pkg::OP_COMPLETE) && valid_c && (id_ff == base_ff);
   assign stat.scan_end  = hit || last_visit;

   // next-state logic
   always_comb begin
      total_in         = total_ff;
      resume_id_in     = resume_id_ff;
      resume_bytes_in  = resume_bytes_ff;
      interval_in      = interval_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      bytes_in         = bytes_ff;
      map_in           = map_ff;
      next_id_in       = next_id_ff;
      base_in          = base_ff;
      base_slot_in     = base_slot_ff;
      next_slot_in     = next_slot_ff;
      last_in          = last_ff;
      btotal_in        = btotal_ff;
      bsince_in        = bsince_ff;
      cur_chunk_in     = cur_chunk_ff;
      vcnt_in          = vcnt_ff;
      found_in         = found_ff;
      found_slot_in    = found_slot_ff;
      cp_in            = cp_ff;
      res_issued_in    = res_issued_ff;
      res_issued_id_in = res_issued_id_ff;
      res_report_in    = res_report_ff;
      res_cp_in        = res_cp_ff;
      res_delta_in     = res_delta_ff;
      res_total_in     = res_total_ff;
      res_status_in    = res_status_ff;
      rsp_tdata_in     = rsp_tdata_ff;
      rsp_tuser_in     = rsp_tuser_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            tcw_pkg::CSR_TOTAL_TASKS:     total_in        = csr_wdata[ID_W-1:0];
            tcw_pkg::CSR_RESUME_TASK_ID:  resume_id_in    = csr_wdata[ID_W-1:0];
            tcw_pkg::CSR_RESUME_BYTES:    resume_bytes_in = csr_wdata[BYTES_W-1:0];
            tcw_pkg::CSR_REPORT_INTERVAL: interval_in     = csr_wdata[ID_W-1:0];
            default: ;
         endcase
      end

      // request capture
      if (cmd.capture) begin
         op_in    = req_tuser[tcw_pkg::OP_W-1:0];
         id_in    = req_tdata[ID_W-1:0];
         bytes_in = req_tdata[ID_W +: BYTES_W];
      end

      // apply the operation
      if (cmd.exec) begin
         res_issued_in    = 1'b0;
         res_issued_id_in = '0;
         res_report_in    = 1'b0;
         res_cp_in        = '0;
         res_delta_in     = '0;
         res_total_in     = '0;
         res_status_in    = tcw_pkg::STATUS_OK;
         found_in         = 1'b0;
         cur_chunk_in     = s_chunk;
         vcnt_in          = '0;
         case (op_ff)
            tcw_pkg::OP_ISSUE: begin
               if (next_id_ff < total_ff) begin
                  if (span >= ID_W'(WINDOW)) begin
                     res_status_in = tcw_pkg::STATUS_FULL;
                  end else begin
                     map_in[next_slot_ff] = 1'b1;
                     res_issued_in        = 1'b1;
                     res_issued_id_in     = next_id_ff;
                     next_id_in           = next_id_ff + 1'b1;
                     next_slot_in         = next_slot_inc;
                  end
               end
            end
            tcw_pkg::OP_COMPLETE: begin
               btotal_in = sat_add(btotal_ff, bytes_ff);
               bsince_in = sat_add(bsince_ff, bytes_ff);
               if (!valid_c) res_status_in = tcw_pkg::STATUS_STRAY;
               else          map_in[slot_c] = 1'b0;
            end
            tcw_pkg::OP_RESTART: begin
               if (resume_id_ff <= total_ff) begin
                  map_in       = '0;
                  next_id_in   = resume_id_ff;
                  base_in      = resume_id_ff;
                  base_slot_in = '0;
                  next_slot_in = '0;
                  last_in      = resume_id_ff;
                  btotal_in    = resume_bytes_ff;
                  bsince_in    = '0;
               end
            end
            default: ;
         endcase
      end

      // one chunk of the lowest-outstanding search
      if (cmd.scan) begin
         if (hit) begin
            found_in      = 1'b1;
            found_slot_in = {cur_chunk_ff, lo_idx};
         end
         cur_chunk_in = chunk_nxt;
         vcnt_in      = vcnt_ff + 1'b1;
      end

      // move the window base to the new checkpoint
      if (cmd.chkpt) begin
         if (found_ff) begin
            cp_in        = cp_found;
            base_in      = cp_found;
            base_slot_in = found_slot_ff[SLOT_W-1:0];
         end else begin
            cp_in        = cp_none;
            base_in      = next_id_ff;
            base_slot_in = next_slot_ff;
         end
      end

      // progress report
      if (cmd.decide && report) begin
         res_report_in = 1'b1;
         res_cp_in     = cp_ff;
         res_delta_in  = bsince_ff;
         res_total_in  = btotal_ff;
         bsince_in     = '0;
         last_in       = cp_ff;
      end

      // response register
      if (cmd.out_load) begin
         rsp_tdata_in = {{(tcw_pkg::RSP_TDATA_W - tcw_pkg::RSP_FIELDS_W){1'b0}},
                         res_total_ff, res_delta_ff, res_cp_ff, res_issued_id_ff};
         rsp_tuser_in = {res_status_ff, res_report_ff, res_issued_ff};
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff        <= '0;
         resume_id_ff    <= '0;
         resume_bytes_ff <= '0;
         interval_ff     <= tcw_pkg::REPORT_INTERVAL_RESET;
         map_ff          <= '0;
         next_id_ff      <= '0;
         base_ff         <= '0;
         base_slot_ff    <= '0;
         next_slot_ff    <= '0;
         last_ff         <= '0;
         btotal_ff       <= '0;
         bsince_ff       <= '0;
         cur_chunk_ff    <= '0;
         vcnt_ff         <= '0;
         found_ff        <= 1'b0;
      end else begin
         total_ff        <= total_in;
         resume_id_ff    <= resume_id_in;
         resume_bytes_ff <= resume_bytes_in;
         interval_ff     <= interval_in;
         map_ff          <= map_in;
         next_id_ff      <= next_id_in;
         base_ff         <= base_in;
         base_slot_ff    <= base_slot_in;
         next_slot_ff    <= next_slot_in;
         last_ff         <= last_in;
         btotal_ff       <= btotal_in;
         bsince_ff       <= bsince_in;
         cur_chunk_ff    <= cur_chunk_in;
         vcnt_ff         <= vcnt_in;
         found_ff        <= found_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      id_ff            <= id_in;
      bytes_ff         <= bytes_in;
      found_slot_ff    <= found_slot_in;
      cp_ff            <= cp_in;
      res_issued_ff    <= res_issued_in;
      res_issued_id_ff <= res_issued_id_in;
      res_report_ff    <= res_report_in;
      res_cp_ff        <= res_cp_in;
      res_delta_ff     <= res_delta_in;
      res_total_ff     <= res_total_in;
      res_status_ff    <= res_status_in;
      rsp_tdata_ff     <= rsp_tdata_in;
      rsp_tuser_ff     <= rsp_tuser_in;
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // window base never passes the next id to issue
   `TCW_ASSERT(a_base_le_next, clock, reset, base_ff <= next_id_ff, "window base above next id")
   // outstanding span fits in the map
   `TCW_ASSERT(a_span_fits, clock, reset, span <= ID_W'(WINDOW), "outstanding span exceeds window")
   // between requests the base slot holds the lowest outstanding id
   `TCW_ASSERT(a_base_outstanding, clock, reset, (cmd.capture && (|map_ff)) |-> map_ff[base_slot_ff], "base id not outstanding")

endmodule

`default_nettype wire

// ===== rtl/task_completion_watermark.sv =====
// ----------------------------------------------------------------------------
// Task completion watermark
// Hands out task ids in order, tracks the outstanding ones in a window and
// raises progress reports as the low watermark advances.
// ----------------------------------------------------------------------------
// One request is processed at a time. Issue, restart, a stray completion and
// a completion of any id other than the lowest outstanding one go from the
// execute state straight to the output state. Completing the lowest
// outstanding id scans the outstanding map 16 slots per cycle starting at
// the window base, then forms the checkpoint and decides on a report; that
// scan is the long path. A new request is accepted while the previous
// response still waits in the output register. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module task_completion_watermark #(
   parameter int WINDOW = tcw_pkg::WINDOW_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   // request: tdata = task_id[31:0], byte_count[94:32]; tuser = operation[1:0]
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [tcw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire  [tcw_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // response: tdata = issued_id[31:0], checkpoint[63:32],
   //           delta_bytes[126:64], total_bytes[189:127]
   //           tuser = issued[0], need_report[1], status[3:2]
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [tcw_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   // register write port
   input  wire                                csr_we,
   input  wire  [tcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tcw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tcw_pkg::cmd_type  cmd;
   tcw_pkg::stat_type stat;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   tcw_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== bench/task_completion_watermark_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Task completion watermark: self-checking testbench
// Streams issue, complete and restart requests into the block through a
// queue-fed driver, predicts every response with a behavioral copy of the
// id window and byte counters, and compares each response field by field.
// A directed opening is followed by randomized phases under varying
// register settings, bursty input and a patterned, stalling receiver.
// ----------------------------------------------------------------------------

module task_completion_watermark_test;
   import tcw_pkg::*;

   localparam int WIN = WINDOW_DEFAULT;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_STALL = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [BYTES_W-1:0] MAX63 = {BYTES_W{1'b1}};
   localparam logic [ID_W-1:0] MAX32 = {ID_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ID_W-1:0]    task_id;
      logic [BYTES_W-1:0] byte_cnt;
   } wm_req_t;

   typedef struct packed {
      logic               issued;
      logic [ID_W-1:0]    issued_id;
      logic               need_report;
      logic [ID_W-1:0]    checkpoint;
      logic [BYTES_W-1:0] delta_bytes;
      logic [BYTES_W-1:0] total_bytes;
      logic [STATUS_W-1:0] status;
   } wm_rsp_t;

   // registers plus the tracker state
   typedef struct packed {
      logic [ID_W-1:0]    total_tasks;
      logic [ID_W-1:0]    resume_id;
      logic [BYTES_W-1:0] resume_bytes;
      logic [ID_W-1:0]    interval;
      logic [WIN-1:0]     busy;
      logic [ID_W-1:0]    next_id;
      logic [ID_W-1:0]    window_base;
      logic [ID_W-1:0]    last_reported;
      logic [BYTES_W-1:0] bytes_total;
      logic [BYTES_W-1:0] bytes_since;
   } wm_state_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wm_state_t gen_st;     // planning copy, stepped as requests are queued
   wm_state_t model_st;   // checking copy, stepped as requests are accepted
   wm_req_t req_pending[$];
   wm_rsp_t rsp_expected[$];
   wm_req_t cur_req;
   bit req_taken = 1'b0;
   int gap_left = 0;
   int burst_left = 0;
   int stall_left = 0;
   int rx_mode = 0;
   int rx_span = 0;
   int rx_tick = 0;
   bit long_stall_go = 1'b0;
   int fail_cnt = 0;
   int quiet_cycles = 0;
   int rand_items = 0;

   task_completion_watermark i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [BYTES_W-1:0] sat_add63(input logic [BYTES_W-1:0] a,
                                                    input logic [BYTES_W-1:0] b);
      logic [BYTES_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[BYTES_W] ? MAX63 : sum[BYTES_W-1:0];
   endfunction

   // one request against the tracker state; returns the response it causes
   function automatic wm_rsp_t watermark_step(inout wm_state_t s, input wm_req_t q);
      wm_rsp_t r;
      logic found;
      logic moved;
      logic [ID_W-1:0] cp;
      longint unsigned k;
      r = '0;
      if (q.op == OP_ISSUE) begin
         if (s.next_id < s.total_tasks) begin
            if (s.next_id - s.window_base >= WIN) begin
               r.status = STATUS_FULL;
            end else begin
               s.busy[s.next_id % WIN] = 1'b1;
               r.issued = 1'b1;
               r.issued_id = s.next_id;
               s.next_id = s.next_id + 1;
            end
         end
      end else if (q.op == OP_COMPLETE) begin
         // bytes count even for a stray completion
         s.bytes_total = sat_add63(s.bytes_total, q.byte_cnt);
         s.bytes_since = sat_add63(s.bytes_since, q.byte_cnt);
         if (q.task_id < s.window_base || q.task_id >= s.next_id ||
             !s.busy[q.task_id % WIN]) begin
            r.status = STATUS_STRAY;
         end else begin
            s.busy[q.task_id % WIN] = 1'b0;
            found = 1'b0;
            cp = '0;
            for (k = s.window_base; k < s.next_id; k++) begin
               if (!found && s.busy[k % WIN]) begin
                  found = 1'b1;
                  cp = ID_W'(k);
               end
            end
            if (!found) begin
               // nothing left: checkpoint is the next id, capped at the total
               cp = (s.next_id >= s.total_tasks) ? s.total_tasks : s.next_id;
               moved = 1'b1;
               s.window_base = s.next_id;
            end else begin
               moved = (cp > q.task_id);
               s.window_base = cp;
            end
            if (moved && (cp == s.total_tasks ||
                          (cp >= s.last_reported && cp - s.last_reported >= s.interval))) begin
               r.need_report = 1'b1;
               r.checkpoint = cp;
               r.delta_bytes = s.bytes_since;
               r.total_bytes = s.bytes_total;
               s.bytes_since = '0;
               s.last_reported = cp;
            end
         end
      end else if (q.op == OP_RESTART) begin
         // a resume point past the total is ignored
         if (s.resume_id <= s.total_tasks) begin
            s.busy = '0;
            s.next_id = s.resume_id;
            s.window_base = s.resume_id;
            s.last_reported = s.resume_id;
            s.bytes_total = s.resume_bytes;
            s.bytes_since = '0;
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_cnt++;
      end
   endfunction

   function automatic logic [BYTES_W-1:0] pick_bytes();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MAX63;
         2, 3: return w[BYTES_W-1:0];
         default: return BYTES_W'($urandom_range(0, 4096));
      endcase
   endfunction

   task automatic push_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [BYTES_W-1:0] nbytes);
      wm_req_t q;
      wm_rsp_t ignored;
      q.op = op;
      q.task_id = id;
      q.byte_cnt = nbytes;
      ignored = watermark_step(gen_st, q);
      req_pending = {req_pending, q};
   endtask

   // all requests sent and every response back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (!(req_pending.size() == 0 && !req_tvalid && rsp_expected.size() == 0));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // reprogram all registers once the block has gone quiet
   task automatic set_config(input logic [ID_W-1:0] tot, input logic [ID_W-1:0] rid,
                             input logic [BYTES_W-1:0] rb, input logic [ID_W-1:0] ivl);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      gen_st.total_tasks = tot;
      gen_st.resume_id = rid;
      gen_st.resume_bytes = rb;
      gen_st.interval = ivl;
      model_st.total_tasks = tot;
      model_st.resume_id = rid;
      model_st.resume_bytes = rb;
      model_st.interval = ivl;
      write_csr(CSR_TOTAL_TASKS, CSR_DATA_W'(tot));
      write_csr(CSR_RESUME_TASK_ID, CSR_DATA_W'(rid));
      write_csr(CSR_RESUME_BYTES, CSR_DATA_W'(rb));
      write_csr(CSR_REPORT_INTERVAL, CSR_DATA_W'(ivl));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         gap_left = 0;
         burst_left = 0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_pending.size() > 0) begin
            cur_req = req_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= REQ_TDATA_W'({cur_req.byte_cnt, cur_req.task_id});
            req_tuser <= cur_req.op;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response receiver: its own stall pattern, plus one long hold-off on demand
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_tick++;
         if (long_stall_go) begin
            long_stall_go = 1'b0;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_span == 0) begin
               rx_mode = $urandom_range(0, 3);
               rx_span = $urandom_range(20, 120);
            end else begin
               rx_span--;
            end
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 9) < 3);
               default: rsp_tready <= (rx_tick % 4 != 0);
            endcase
         end
      end
   end

   // monitor: check responses, predict accepted requests, watch for a hang
   always @(posedge clock) begin : monitor
      wm_rsp_t want;
      wm_rsp_t got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.issued = rsp_tuser[0];
            got.need_report = rsp_tuser[1];
            got.status = rsp_tuser[3:2];
            got.issued_id = rsp_tdata[31:0];
            got.checkpoint = rsp_tdata[63:32];
            got.delta_bytes = rsp_tdata[126:64];
            got.total_bytes = rsp_tdata[189:127];
            if (rsp_expected.size() == 0) begin
               $error("response with no request waiting for one");
               fail_cnt++;
            end else begin
               want = rsp_expected.pop_front();
               check_field("issued", 64'(want.issued), 64'(got.issued));
               check_field("issued_id", 64'(want.issued_id), 64'(got.issued_id));
               check_field("need_report", 64'(want.need_report), 64'(got.need_report));
               check_field("checkpoint", 64'(want.checkpoint), 64'(got.checkpoint));
               check_field("delta_bytes", 64'(want.delta_bytes), 64'(got.delta_bytes));
               check_field("total_bytes", 64'(want.total_bytes), 64'(got.total_bytes));
               check_field("status", 64'(want.status), 64'(got.status));
            end
         end
         if (req_tvalid && req_tready) begin
            rsp_expected = {rsp_expected, watermark_step(model_st, cur_req)};
            req_taken = 1'b1;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int ph;
      int i;
      int n_items;
      int issue_pct;
      int sel;
      logic [ID_W-1:0] tot;
      logic [ID_W-1:0] rid;
      logic [ID_W-1:0] ivl;
      logic [ID_W-1:0] sid;
      logic [BYTES_W-1:0] rb;
      logic [63:0] w;
      longint unsigned k;
      logic [ID_W-1:0] live[$];

      gen_st = '0;
      gen_st.interval = REPORT_INTERVAL_RESET;
      model_st = gen_st;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // reset settings: nothing to issue, stray completion of the largest byte count, unused op
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_COMPLETE, '0, MAX63);
      push_req(OP_UNUSED, MAX32, MAX63);
      push_req(OP_RESTART, '0, '0);

      // resume point past the total is ignored
      set_config(32'd15, 32'd20, MAX63, 32'd1);
      push_req(OP_RESTART, '0, '0);

      // resume near the end; out-of-order completion, report at the total
      set_config(32'd15, 32'd12, MAX63, 32'd1);
      push_req(OP_RESTART, '0, '0);
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_COMPLETE, 32'd13, 63'd5);
      push_req(OP_COMPLETE, 32'd12, 63'd7);
      push_req(OP_COMPLETE, 32'd14, '0);
      push_req(OP_COMPLETE, 32'd14, 63'd1);
      push_req(OP_COMPLETE, MAX32, MAX63);

      // huge interval: checkpoint moves without a report
      set_config(MAX32, '0, '0, MAX32);
      push_req(OP_RESTART, '0, '0);
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_ISSUE, '0, '0);
      push_req(OP_COMPLETE, 32'd1, 63'd100);
      push_req(OP_COMPLETE, 32'd0, 63'd200);

      // randomized phases, each under its own register settings
      for (ph = 0; rand_items < 1650; ph++) begin
         if (ph == 0) begin
            tot = MAX32;
            rid = 32'hFFFF_FFB0;
            rb = MAX63 - 63'd50;
            ivl = MAX32;
            issue_pct = 60;
         end else if (ph == 1) begin
            tot = $urandom_range(20, 60);
            rid = '0;
            rb = '0;
            ivl = 32'd1;
            issue_pct = 50;
         end else begin
            case ($urandom_range(0, 3))
               0: tot = $urandom_range(0, 40);
               1: tot = $urandom_range(40, 400);
               2: tot = MAX32;
               default: tot = $urandom;
            endcase
            case ($urandom_range(0, 5))
               0: rid = '0;
               1: rid = tot;
               2: rid = (tot > 10) ? tot - $urandom_range(0, 10) : tot;
               3: rid = (tot != MAX32) ? tot + 1 : $urandom;
               default: rid = $urandom_range(0, tot);
            endcase
            w = {$urandom, $urandom};
            case ($urandom_range(0, 3))
               0: rb = '0;
               1: rb = MAX63;
               2: rb = w[BYTES_W-1:0];
               default: rb = MAX63 - BYTES_W'($urandom_range(0, 1000));
            endcase
            case ($urandom_range(0, 4))
               0: ivl = 32'd1;
               1: ivl = $urandom_range(1, 16);
               2: ivl = $urandom_range(1, 300);
               3: ivl = MAX32;
               default: ivl = $urandom | 32'd1;
            endcase
            issue_pct = $urandom_range(25, 70);
         end
         set_config(tot, rid, rb, ivl);
         // receiver holds off while the sender keeps offering
         if (ph == 1) long_stall_go = 1'b1;
         push_req(OP_RESTART, $urandom, pick_bytes());
         n_items = $urandom_range(40, 160);
         for (i = 0; i < n_items; i++) begin
            // sender pauses until every response is back
            if (ph == 2 && i == n_items / 2) wait_drained();
            sel = $urandom_range(0, 99);
            if (sel >= 98) begin
               push_req(OP_UNUSED, $urandom, pick_bytes());
            end else begin
               rand_items++;
               if (sel >= 96) begin
                  push_req(OP_RESTART, $urandom, pick_bytes());
               end else if (sel >= 92) begin
                  case ($urandom_range(0, 3))
                     0: sid = $urandom;
                     1: sid = gen_st.window_base - 1;
                     2: sid = gen_st.next_id;
                     default: sid = gen_st.window_base + $urandom_range(0, WIN - 1);
                  endcase
                  push_req(OP_COMPLETE, sid, pick_bytes());
               end else begin
                  live.delete();
                  for (k = gen_st.window_base; k < gen_st.next_id; k++) begin
                     if (gen_st.busy[k % WIN]) live = {live, ID_W'(k)};
                  end
                  if (sel < issue_pct || live.size() == 0) begin
                     push_req(OP_ISSUE, $urandom, pick_bytes());
                  end else begin
                     // favor the lowest id so the watermark advances often
                     if ($urandom_range(0, 9) < 4) sid = live[0];
                     else sid = live[$urandom_range(0, live.size() - 1)];
                     push_req(OP_COMPLETE, sid, pick_bytes());
                  end
               end
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      #1;
      if (fail_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
